### src/multichannel_square_tone_synth_unit_defines.svh
// Assertion macros used by the tone synth RTL (the sequencer, msts_ctrl).
// Checks compile out when SYNTHESIS is defined.
`ifndef MULTICHANNEL_SQUARE_TONE_SYNTH_UNIT_DEFINES_SVH
`define MULTICHANNEL_SQUARE_TONE_SYNTH_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
// Antecedent implies consequent in the same cycle
`define MSTS_ASSERT_IMP(lbl, a, c, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) else $error(msg);
// Antecedent implies consequent in the next cycle
`define MSTS_ASSERT_NXT(lbl, a, c, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) else $error(msg);
`else
`define MSTS_ASSERT_IMP(lbl, a, c, msg)
`define MSTS_ASSERT_NXT(lbl, a, c, msg)
`endif
`endif

### src/msts_pkg.sv
// Types, constants and the note frequency table of the tone synth.
// No dependencies.
`default_nettype none
package msts_pkg;

    typedef enum logic [1:0] {
        REQ_TICK = 2'd0,
        REQ_PLAY = 2'd1,
        REQ_STOP = 2'd2,
        REQ_TONE = 2'd3
    } req_t;

    typedef enum logic [1:0] {
        CFG_MODE  = 2'd0,
        CFG_WIDTH = 2'd1,
        CFG_RATE  = 2'd2
    } cfg_idx_t;

    typedef enum logic [2:0] {
        OP_NOP    = 3'd0,
        OP_LATCH  = 3'd1,
        OP_QSTART = 3'd2,
        OP_SSTART = 3'd3,
        OP_DSTART = 3'd4,
        OP_APPLY  = 3'd5,
        OP_WALK   = 3'd6,
        OP_EMIT   = 3'd7
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
        logic   idle;
    } dp_cmd_t;

    typedef struct packed {
        logic in_valid;
        req_t req;
        logic ch_ok;
        logic tone_pend;
        logic div_done;
        logic walk_last;
        logic out_free;
    } dp_stat_t;

    localparam int RATE_W = 18;
    localparam int DIV_W  = 34;
    localparam logic [RATE_W-1:0] RATE_RESET  = 18'd22050;
    localparam logic [7:0]        WIDTH_RESET = 8'd128;
    // Divide by 1000 for x below 2^34: ((x >> 3) * MS_RECIP) >> MS_SHIFT
    localparam logic [31:0]       MS_RECIP    = 32'd2199023256;
    localparam int                MS_SHIFT    = 38;
    localparam logic [DIV_W-1:0]  PHASE_FULL  = 34'h1_0000_0000;
    localparam logic [31:0]       ENDLESS     = 32'hffff_ffff;
    localparam logic [7:0]        LEVEL_MAX   = 8'd255;
    localparam logic [7:0]        PIN_HIGH    = 8'd128;

    localparam logic [15:0] NOTE_HZ [128] = '{
        16'd16, 16'd17, 16'd18, 16'd19, 16'd21, 16'd22, 16'd23, 16'd24,
        16'd26, 16'd28, 16'd29, 16'd31, 16'd33, 16'd35, 16'd37, 16'd39,
        16'd41, 16'd44, 16'd46, 16'd49, 16'd52, 16'd55, 16'd58, 16'd62,
        16'd65, 16'd69, 16'd73, 16'd78, 16'd82, 16'd87, 16'd92, 16'd98,
        16'd104, 16'd110, 16'd117, 16'd123, 16'd131, 16'd139, 16'd147, 16'd156,
        16'd165, 16'd175, 16'd185, 16'd196, 16'd208, 16'd220, 16'd233, 16'd247,
        16'd262, 16'd277, 16'd294, 16'd311, 16'd330, 16'd349, 16'd370, 16'd392,
        16'd415, 16'd440, 16'd466, 16'd494, 16'd523, 16'd554, 16'd587, 16'd622,
        16'd659, 16'd698, 16'd740, 16'd784, 16'd831, 16'd880, 16'd932, 16'd988,
        16'd1047, 16'd1109, 16'd1175, 16'd1245, 16'd1319, 16'd1397, 16'd1480,
        16'd1568, 16'd1661, 16'd1760, 16'd1865, 16'd1976, 16'd2093, 16'd2217,
        16'd2349, 16'd2489, 16'd2637, 16'd2794, 16'd2960, 16'd3136, 16'd3322,
        16'd3520, 16'd3729, 16'd3951, 16'd4186, 16'd4435, 16'd4699, 16'd4978,
        16'd5274, 16'd5588, 16'd5920, 16'd6272, 16'd6645, 16'd7040, 16'd7459,
        16'd7902, 16'd8372, 16'd8870, 16'd9397, 16'd9956, 16'd10548, 16'd11175,
        16'd11840, 16'd12544, 16'd13290, 16'd14080, 16'd14917, 16'd15804,
        16'd16744, 16'd17740, 16'd18795, 16'd19912, 16'd21096, 16'd22351,
        16'd23680, 16'd25088
    };

endpackage
`default_nettype wire

### src/multichannel_square_tone_synth_unit.sv
// Multichannel square tone synth, top level.
// Input words carry a request: sample tick, play note, stop note or tone on
// the last channel. Each tick gives one output word (sample); other requests
// give none. Both channels use valid/stall; config is a plain write port.
// After acceptance, a tick walks the channels one per cycle, then delivers
// its sample through the output register; stop is applied at acceptance;
// play runs the divider twice; tone runs the same two divider runs, then a
// reciprocal multiply for the length in ticks.
// Play and tone share the one bit-serial divider. One word is in work at a
// time; in_stall is high until the sequencer is idle again.
// A tick whose sample finds the output register still held waits until the
// receiver takes the earlier word; in_stall stays high meanwhile.
// Reset clears all channels, the level and the output; config returns to
// square mode, width 128 and 22050 Hz.
// Depends on msts_pkg, msts_ctrl, msts_dp and msts_div.
`default_nettype none
module multichannel_square_tone_synth_unit #(
    parameter int CHANNELS = 4
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       cfg_we,
    input  wire logic [1:0]                 cfg_index,
    input  wire logic [msts_pkg::RATE_W-1:0] cfg_data,
    input  wire logic                       in_valid,
    output logic                            in_stall,
    input  wire logic [1:0]                 req_type,
    input  wire logic [3:0]                 channel,
    input  wire logic [6:0]                 note,
    input  wire logic [15:0]                tone_freq,
    input  wire logic [15:0]                tone_ms,
    output logic                            out_valid,
    input  wire logic                       out_stall,
    output logic [7:0]                      sample
);
    import msts_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t st;

    msts_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .st    (st),
        .cmd   (cmd)
    );

    msts_dp #(
        .CHANNELS (CHANNELS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .st        (st),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .req_type  (req_type),
        .channel   (channel),
        .note      (note),
        .tone_freq (tone_freq),
        .tone_ms   (tone_ms),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .sample    (sample)
    );

    // Input taken only while the sequencer is idle
    assign in_stall = !cmd.idle;

endmodule
`default_nettype wire

### src/msts_div.sv
// Restoring divider, one quotient bit per cycle.
// Depends on msts_pkg for widths.
`default_nettype none
module msts_div (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       start,
    input  wire logic [msts_pkg::DIV_W-1:0]  dividend,
    input  wire logic [msts_pkg::RATE_W-1:0] divisor,
    output logic                            done,
    output logic [msts_pkg::DIV_W-1:0]       quotient
);
    import msts_pkg::*;

    localparam int CNT_W = $clog2(DIV_W + 1);

    logic [DIV_W-1:0]  quo_reg, quo_next;
    logic [RATE_W-1:0] rem_reg, rem_next;
    logic [RATE_W-1:0] dsr_reg;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [RATE_W:0]   trial;
    logic [RATE_W:0]   diff;

    // One shift-subtract step
    always_comb
    begin
        trial    = {rem_reg, quo_reg[DIV_W-1]};
        diff     = trial - {1'b0, dsr_reg};
        quo_next = {quo_reg[DIV_W-2:0], 1'b0};
        rem_next = trial[RATE_W-1:0];
        cnt_next = cnt_reg;
        if (cnt_reg != '0)
        begin
            cnt_next = cnt_reg - CNT_W'(1);
            if (trial >= {1'b0, dsr_reg})
            begin
                rem_next    = diff[RATE_W-1:0];
                quo_next[0] = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (start)
        begin
            cnt_reg <= CNT_W'(DIV_W);
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dsr_reg <= divisor;
        end
        else if (cnt_reg != '0)
        begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
    end

    assign done     = (cnt_reg == CNT_W'(1));
    assign quotient = quo_reg;

endmodule
`default_nettype wire

### src/msts_ctrl.sv
// Sequencer of the tone synth: steps the datapath through requests.
// Depends on msts_pkg and the assertion macro header.
`default_nettype none
`include "multichannel_square_tone_synth_unit_defines.svh"
module msts_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire msts_pkg::dp_stat_t st,
    output msts_pkg::dp_cmd_t       cmd
);
    import msts_pkg::*;

    typedef enum logic [9:0] {
        S_IDLE   = 10'b00_0000_0001,
        S_QSTART = 10'b00_0000_0010,
        S_QWAIT  = 10'b00_0000_0100,
        S_SSTART = 10'b00_0000_1000,
        S_SWAIT  = 10'b00_0001_0000,
        S_DSTART = 10'b00_0010_0000,
        S_DWAIT  = 10'b00_0100_0000,
        S_APPLY  = 10'b00_1000_0000,
        S_WALK   = 10'b01_0000_0000,
        S_EMIT   = 10'b10_0000_0000
    } state_t;

    state_t state_reg, state_next;

    // Next state and command decode
    always_comb
    begin
        state_next = state_reg;
        cmd.op     = OP_NOP;
        cmd.idle   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                cmd.idle = 1'b1;
                if (st.in_valid)
                begin
                    cmd.op = OP_LATCH;
                    unique case (st.req)
                        REQ_TICK: state_next = S_WALK;
                        REQ_PLAY: state_next = st.ch_ok ? S_QSTART : S_IDLE;
                        REQ_STOP: state_next = S_IDLE;
                        REQ_TONE: state_next = S_QSTART;
                        default:  state_next = S_IDLE;
                    endcase
                end
            end
            S_QSTART:
            begin
                cmd.op     = OP_QSTART;
                state_next = S_QWAIT;
            end
            S_QWAIT:
            begin
                if (st.div_done)
                    state_next = S_SSTART;
            end
            S_SSTART:
            begin
                cmd.op     = OP_SSTART;
                state_next = S_SWAIT;
            end
            S_SWAIT:
            begin
                if (st.div_done)
                    state_next = st.tone_pend ? S_DSTART : S_APPLY;
            end
            S_DSTART:
            begin
                cmd.op     = OP_DSTART;
                state_next = S_DWAIT;
            end
            S_DWAIT:
            begin
                // duration product register settles
                state_next = S_APPLY;
            end
            S_APPLY:
            begin
                cmd.op     = OP_APPLY;
                state_next = S_IDLE;
            end
            S_WALK:
            begin
                cmd.op = OP_WALK;
                if (st.walk_last)
                    state_next = S_EMIT;
            end
            S_EMIT:
            begin
                cmd.op = OP_EMIT;
                if (st.out_free)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    `MSTS_ASSERT_NXT(a_walk_runs, (state_reg == S_WALK) && !st.walk_last, state_reg == S_WALK, "walk ended early")
    `MSTS_ASSERT_IMP(a_done_waits, st.div_done, (state_reg == S_QWAIT) || (state_reg == S_SWAIT) || (state_reg == S_DWAIT), "divider done outside a wait state")
    `MSTS_ASSERT_NXT(a_emit_idle, (state_reg == S_EMIT) && st.out_free, state_reg == S_IDLE, "emit did not return to idle")

endmodule
`default_nettype wire

### src/msts_dp.sv
// Datapath of the tone synth: channel state, config, divider and output word.
// Depends on msts_pkg and msts_div.
`default_nettype none
module msts_dp #(
    parameter int CHANNELS = 4
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire msts_pkg::dp_cmd_t          cmd,
    output msts_pkg::dp_stat_t              st,
    input  wire logic                       cfg_we,
    input  wire logic [1:0]                 cfg_index,
    input  wire logic [msts_pkg::RATE_W-1:0] cfg_data,
    input  wire logic                       in_valid,
    input  wire logic [1:0]                 req_type,
    input  wire logic [3:0]                 channel,
    input  wire logic [6:0]                 note,
    input  wire logic [15:0]                tone_freq,
    input  wire logic [15:0]                tone_ms,
    output logic                            out_valid,
    input  wire logic                       out_stall,
    output logic [7:0]                      sample
);
    import msts_pkg::*;

    localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam logic [CH_W-1:0] LAST_CH = CH_W'(CHANNELS - 1);
    localparam logic [7:0] EACH = 8'(128 - 8 * CHANNELS);

    // Config registers
    logic              mode_reg;
    logic [7:0]        width_reg;
    logic [RATE_W-1:0] rate_reg;

    // Channel state
    logic [31:0] phase_acc_reg  [CHANNELS];
    logic [31:0] phase_step_reg [CHANNELS];
    logic [31:0] ticks_left_reg [CHANNELS];
    logic [7:0]  level_reg;

    // Request working registers
    logic              tone_reg;
    logic [CH_W-1:0]   ch_reg;
    logic [15:0]       hz_reg;
    logic [DIV_W-1:0]  prod_reg;
    logic [62:0]       dur_mul_reg;
    logic              zero_reg;
    logic [31:0]       step_hold_reg;
    logic [CH_W-1:0]   idx_reg;
    logic [7:0]        sum_reg;
    logic [7:0]        pend_reg;
    logic              out_valid_reg;
    logic [7:0]        sample_reg;

    // Divider
    logic              div_start;
    logic [DIV_W-1:0]  div_dividend;
    logic [RATE_W-1:0] div_divisor;
    logic              div_done;
    logic [DIV_W-1:0]  quot;

    logic        ch_ok;
    logic [31:0] w_acc;
    logic [31:0] w_step;
    logic [31:0] w_ticks;
    logic [32:0] w_sum;
    logic        w_active;
    logic [8:0]  sum_add;
    logic        out_free;
    logic [CH_W-1:0] apply_ch;
    logic [31:0]     apply_step;
    logic [31:0]     dur_ticks;

    assign ch_ok = (channel < 4'(CHANNELS));

    // Tone length in ticks: rate * ms / 1000 by reciprocal multiply
    assign dur_ticks = 32'(dur_mul_reg[62:MS_SHIFT]);

    // Divider operand select
    always_comb
    begin
        div_start    = 1'b0;
        div_dividend = PHASE_FULL;
        div_divisor  = quot[RATE_W-1:0];
        case (cmd.op)
            OP_QSTART:
            begin
                div_start    = 1'b1;
                div_dividend = DIV_W'(rate_reg);
                div_divisor  = RATE_W'(hz_reg);
            end
            OP_SSTART:
            begin
                div_start = 1'b1;
            end
            default:
            begin
                div_start = 1'b0;
            end
        endcase
    end

    msts_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (quot)
    );

    // Channel under the walk
    always_comb
    begin
        w_acc    = phase_acc_reg[idx_reg];
        w_step   = phase_step_reg[idx_reg];
        w_ticks  = ticks_left_reg[idx_reg];
        w_active = (w_ticks != '0);
        w_sum    = {1'b0, w_acc} + {1'b0, w_step};
        sum_add  = {1'b0, sum_reg} + {1'b0, EACH};
        apply_ch = tone_reg ? LAST_CH : ch_reg;
        apply_step = zero_reg ? '0 : (tone_reg ? step_hold_reg : quot[31:0]);
    end

    assign out_free = !out_valid_reg || !out_stall;

    // Config writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= 1'b0;
            width_reg <= WIDTH_RESET;
            rate_reg  <= RATE_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_MODE:  mode_reg  <= cfg_data[0];
                CFG_WIDTH: width_reg <= cfg_data[7:0];
                CFG_RATE:  rate_reg  <= cfg_data;
                default:   mode_reg  <= mode_reg;
            endcase
        end
    end

    // Channel state and level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CHANNELS; i++)
            begin
                phase_acc_reg[i]  <= '0;
                phase_step_reg[i] <= '0;
                ticks_left_reg[i] <= '0;
            end
            level_reg <= '0;
        end
        else
        begin
            case (cmd.op)
                OP_LATCH:
                begin
                    if (req_t'(req_type) == REQ_STOP && ch_ok)
                    begin
                        phase_acc_reg[channel[CH_W-1:0]]  <= '0;
                        phase_step_reg[channel[CH_W-1:0]] <= '0;
                    end
                    if (req_t'(req_type) == REQ_TICK && mode_reg && level_reg != '0)
                        level_reg <= level_reg - 8'd1;
                end
                OP_APPLY:
                begin
                    phase_acc_reg[apply_ch]  <= '0;
                    phase_step_reg[apply_ch] <= apply_step;
                    ticks_left_reg[apply_ch] <= tone_reg ? dur_ticks : ENDLESS;
                end
                OP_WALK:
                begin
                    if (w_active)
                    begin
                        if (w_ticks != ENDLESS)
                            ticks_left_reg[idx_reg] <= w_ticks - 32'd1;
                        phase_acc_reg[idx_reg] <= w_sum[31:0];
                        if (mode_reg && w_sum[32])
                            level_reg <= width_reg;
                    end
                end
                OP_EMIT:
                begin
                    if (!mode_reg)
                        level_reg <= sum_reg;
                end
                default:
                begin
                    level_reg <= level_reg;
                end
            endcase
        end
    end

    // Request working registers
    always_ff @(posedge clk)
    begin
        case (cmd.op)
            OP_LATCH:
            begin
                tone_reg <= (req_t'(req_type) == REQ_TONE);
                ch_reg   <= channel[CH_W-1:0];
                hz_reg   <= (req_t'(req_type) == REQ_TONE) ? tone_freq : NOTE_HZ[note];
                prod_reg <= DIV_W'(rate_reg) * DIV_W'(tone_ms);
                idx_reg  <= '0;
                sum_reg  <= '0;
                pend_reg <= mode_reg ? ((level_reg != '0) ? PIN_HIGH : 8'd0) : level_reg;
            end
            OP_SSTART:
            begin
                zero_reg <= (hz_reg == '0) || (quot == '0);
            end
            OP_DSTART:
            begin
                step_hold_reg <= quot[31:0];
                dur_mul_reg   <= 63'(prod_reg[DIV_W-1:3]) * 63'(MS_RECIP);
            end
            OP_WALK:
            begin
                if (idx_reg != LAST_CH)
                    idx_reg <= idx_reg + CH_W'(1);
                if (!mode_reg && w_active && (w_sum[31:0] > {width_reg, 24'd0}))
                    sum_reg <= sum_add[8] ? LEVEL_MAX : sum_add[7:0];
            end
            default:
            begin
                sum_reg <= sum_reg;
            end
        endcase
    end

    // Output word register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.op == OP_EMIT && out_free)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.op == OP_EMIT && out_free)
            sample_reg <= pend_reg;
    end

    assign out_valid = out_valid_reg;
    assign sample    = sample_reg;

    // Status back to the sequencer
    always_comb
    begin
        st.in_valid  = in_valid;
        st.req       = req_t'(req_type);
        st.ch_ok     = ch_ok;
        st.tone_pend = tone_reg;
        st.div_done  = div_done;
        st.walk_last = (idx_reg == LAST_CH);
        st.out_free  = out_free;
    end

endmodule
`default_nettype wire

### verif/multichannel_square_tone_synth_unit_tb.sv
// Testbench for the multichannel square tone synth: directed table, then random
// request streams checked word by word against a behavioural predictor.
// Depends on msts_pkg and multichannel_square_tone_synth_unit.
`default_nettype none
module multichannel_square_tone_synth_unit_tb;
    import msts_pkg::*;

    localparam int NCH       = 4;
    localparam int N_RANDOM  = 1850;
    localparam int CYCLE_CAP = 2000000;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [17:0] cfg_data;
    logic        in_valid;
    logic        in_stall;
    logic [1:0]  req_type;
    logic [3:0]  channel;
    logic [6:0]  note;
    logic [15:0] tone_freq;
    logic [15:0] tone_ms;
    logic        out_valid;
    logic        out_stall;
    logic [7:0]  sample;

    multichannel_square_tone_synth_unit #(.CHANNELS(NCH)) u_top (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_stall(in_stall),
        .req_type(req_type), .channel(channel), .note(note),
        .tone_freq(tone_freq), .tone_ms(tone_ms),
        .out_valid(out_valid), .out_stall(out_stall), .sample(sample)
    );

    // Predictor state
    logic        mode_q;
    logic [7:0]  width_q;
    logic [17:0] rate_q;
    logic [31:0] acc_q   [NCH];
    logic [31:0] inc_q   [NCH];
    logic [31:0] dur_q   [NCH];
    logic [7:0]  level_q;

    logic [7:0] samples_due[$];
    int errors;
    int cycles;
    int ticks_sent;
    int samples_seen;
    bit stall_on;

    typedef struct {
        req_t        req;
        logic [3:0]  ch;
        logic [6:0]  nt;
        logic [15:0] hz;
        logic [15:0] ms;
        int          want;   // -1: take from predictor
    } row_t;

    initial clk = 1'b0;
    always #5 clk = ~clk;

    function automatic logic [31:0] phase_inc(input logic [31:0] hz);
        logic [63:0] q;
        logic [63:0] full;
        full = 64'h1_0000_0000;
        if (hz == 0) return 32'd0;
        q = 64'(rate_q) / 64'(hz);
        if (q == 0) return 32'd0;
        return 32'(full / q);
    endfunction

    // Apply one request to the predictor; queue a sample for a tick
    task automatic synth_predict(input req_t rq, input logic [3:0] ch,
                                 input logic [6:0] nt, input logic [15:0] hz,
                                 input logic [15:0] ms);
        logic [63:0] d;
        logic [31:0] prev;
        int          sum;
        case (rq)
            REQ_PLAY: if (ch < NCH)
            begin
                acc_q[ch] = 0;
                inc_q[ch] = phase_inc(32'(NOTE_HZ[nt]));
                dur_q[ch] = ENDLESS;
            end
            REQ_STOP: if (ch < NCH)
            begin
                acc_q[ch] = 0;
                inc_q[ch] = 0;
            end
            REQ_TONE:
            begin
                d = 64'(rate_q) * 64'(ms) / 64'd1000;
                acc_q[NCH-1] = 0;
                inc_q[NCH-1] = phase_inc(32'(hz));
                dur_q[NCH-1] = d[31:0];
            end
            default:
            begin
                if (!mode_q)
                begin
                    samples_due.push_back(level_q);
                    sum = 0;
                    for (int i = 0; i < NCH; i++)
                        if (dur_q[i] != 0)
                        begin
                            if (dur_q[i] != ENDLESS) dur_q[i]--;
                            acc_q[i] += inc_q[i];
                            if (acc_q[i] > {width_q, 24'd0}) sum += 128 - 8 * NCH;
                        end
                    level_q = (sum > 255) ? LEVEL_MAX : 8'(sum);
                end
                else
                begin
                    samples_due.push_back(level_q != 0 ? PIN_HIGH : 8'd0);
                    if (level_q != 0) level_q--;
                    for (int i = 0; i < NCH; i++)
                        if (dur_q[i] != 0)
                        begin
                            prev = acc_q[i];
                            if (dur_q[i] != ENDLESS) dur_q[i]--;
                            acc_q[i] += inc_q[i];
                            if (acc_q[i] < prev) level_q = width_q;
                        end
                end
            end
        endcase
    endtask

    // Send one word, with bursty gaps before it; valid stays up between words unless a gap is drawn
    task automatic send_word(input req_t rq, input logic [3:0] ch, input logic [6:0] nt,
                             input logic [15:0] hz, input logic [15:0] ms);
        if ($urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge clk);
        end
        req_type  <= rq;
        channel   <= ch;
        note      <= nt;
        tone_freq <= hz;
        tone_ms   <= ms;
        in_valid  <= 1'b1;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        synth_predict(rq, ch, nt, hz, ms);
        if (rq == REQ_TICK) ticks_sent++;
        @(negedge clk);
    endtask

    task automatic drain_and_settle();
        in_valid <= 1'b0;
        while (samples_due.size() != 0) @(negedge clk);
        // play/tone may still be dividing; allow the longest request time
        repeat (200) @(negedge clk);
    endtask

    task automatic write_reg(input cfg_idx_t idx, input logic [17:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_MODE:  mode_q  = val[0];
            CFG_WIDTH: width_q = val[7:0];
            default:   rate_q  = val;
        endcase
        @(negedge clk);
    endtask

    // Result checking at the rising edge
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            samples_seen++;
            if (samples_due.size() == 0)
            begin
                $display("%0t: unexpected sample word, expected none, actual %0d",
                         $time, sample);
                errors++;
            end
            else
            begin
                if (sample !== samples_due[0])
                begin
                    $display("%0t: sample mismatch, expected %0d, actual %0d",
                             $time, samples_due[0], sample);
                    errors++;
                end
                void'(samples_due.pop_front());
            end
        end
    end

    // Receiver stall: alternating stretches of clear and patchy back-pressure
    always @(negedge clk)
    begin
        if ($urandom_range(0, 63) == 0) stall_on <= ~stall_on;
        out_stall <= stall_on ? ($urandom_range(0, 2) == 0) : 1'b0;
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_CAP)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Random request: mostly ticks, some notes, occasional tones and oddities
    task automatic random_word();
        int          pick;
        logic [15:0] hz;
        logic [15:0] ms;
        pick = $urandom_range(0, 99);
        hz = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(20, 4000));
        ms = ($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'($urandom_range(0, 30));
        if (pick < 70)
            send_word(REQ_TICK, 4'($urandom), 7'($urandom), 16'($urandom), 16'($urandom));
        else if (pick < 85)
            send_word(REQ_PLAY, 4'($urandom_range(0, 5)), 7'($urandom), 16'($urandom),
                      16'($urandom));
        else if (pick < 93)
            send_word(REQ_STOP, 4'($urandom_range(0, 15)), 7'($urandom), 16'($urandom),
                      16'($urandom));
        else
            send_word(REQ_TONE, 4'($urandom), 7'($urandom), hz, ms);
    endtask

    initial
    begin
        row_t rows[$];
        logic [17:0] rates[4];
        logic [7:0]  widths[4];

        rst_n = 1'b0;
        cfg_we = 1'b0; cfg_index = CFG_MODE; cfg_data = '0;
        in_valid = 1'b0; req_type = REQ_TICK; channel = '0; note = '0;
        tone_freq = '0; tone_ms = '0; out_stall = 1'b0;
        stall_on = 1'b0; errors = 0; cycles = 0; ticks_sent = 0; samples_seen = 0;
        mode_q = 1'b0; width_q = WIDTH_RESET; rate_q = RATE_RESET; level_q = 0;
        for (int i = 0; i < NCH; i++)
        begin
            acc_q[i] = 0; inc_q[i] = 0; dur_q[i] = 0;
        end
        repeat (9) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed table: reset level, extremes, out-of-range channels, silent tone
        rows = '{
            '{REQ_TICK, 4'd0,  7'd0,   16'd0,     16'd0,     0},
            '{REQ_TICK, 4'd15, 7'd127, 16'hffff,  16'hffff,  0},
            '{REQ_PLAY, 4'd0,  7'd0,   16'd0,     16'd0,     -1},
            '{REQ_PLAY, 4'd1,  7'd127, 16'd0,     16'd0,     -1},
            '{REQ_PLAY, 4'd15, 7'd60,  16'd0,     16'd0,     -1},
            '{REQ_PLAY, 4'd4,  7'd60,  16'd0,     16'd0,     -1},
            '{REQ_TICK, 4'd0,  7'd0,   16'd0,     16'd0,     0},
            '{REQ_TICK, 4'd0,  7'd0,   16'd0,     16'd0,     -1},
            '{REQ_TONE, 4'd0,  7'd0,   16'd0,     16'd50,    -1},
            '{REQ_TICK, 4'd0,  7'd0,   16'd0,     16'd0,     -1},
            '{REQ_TONE, 4'd0,  7'd0,   16'hffff,  16'd10,    -1},
            '{REQ_TICK, 4'd0,  7'd0,   16'd0,     16'd0,     -1},
            '{REQ_TONE, 4'd0,  7'd0,   16'd22050, 16'd1,     -1},
            '{REQ_TICK, 4'd0,  7'd0,   16'd0,     16'd0,     -1},
            '{REQ_TONE, 4'd0,  7'd0,   16'd440,   16'd0,     -1},
            '{REQ_TONE, 4'd0,  7'd0,   16'd1,     16'hffff,  -1},
            '{REQ_TICK, 4'd0,  7'd0,   16'd0,     16'd0,     -1},
            '{REQ_STOP, 4'd1,  7'd0,   16'd0,     16'd0,     -1},
            '{REQ_STOP, 4'd14, 7'd0,   16'd0,     16'd0,     -1},
            '{REQ_TICK, 4'd0,  7'd0,   16'd0,     16'd0,     -1},
            '{REQ_TICK, 4'd0,  7'd0,   16'd0,     16'd0,     -1}
        };
        foreach (rows[r])
        begin
            send_word(rows[r].req, rows[r].ch, rows[r].nt, rows[r].hz, rows[r].ms);
            if (rows[r].want >= 0 && samples_due.size() != 0
                && samples_due[$] != 8'(rows[r].want))
            begin
                $display("%0t: directed row %0d, expected %0d, actual %0d",
                         $time, r, rows[r].want, samples_due[$]);
                errors++;
            end
        end
        drain_and_settle();

        // Random phases across register settings, extremes included
        rates  = '{18'd1000, 18'd200000, 18'd22050, 18'd8000};
        widths = '{8'd0, 8'd255, 8'd128, 8'd3};
        for (int p = 0; p < 8; p++)
        begin
            write_reg(CFG_MODE, 18'(p % 2));
            write_reg(CFG_WIDTH, 18'(p < 4 ? widths[p] : $urandom_range(0, 255)));
            write_reg(CFG_RATE, p < 4 ? rates[p] : 18'($urandom_range(1000, 200000)));
            for (int k = 0; k < N_RANDOM / 8; k++) random_word();
            drain_and_settle();
        end
        write_reg(CFG_RATE, 18'h3ffff);
        for (int k = 0; k < 40; k++) random_word();
        drain_and_settle();

        $display("Ran %0d tick words, %0d sample words checked, both synth modes and rate",
                 ticks_sent, samples_seen);
        $display("and width extremes, with random sender gaps and receiver stalls.");
        if (errors == 0 && samples_due.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end
endmodule
`default_nettype wire
